### rtl/crbo_pkg.sv
// shared constants, codes and sprite image for the cursor rubber-band overlay
`timescale 1ns / 1ps
`default_nettype none
package crbo_pkg;

  localparam int SCREEN_W    = 640;
  localparam int SCREEN_H    = 480;
  localparam int SPRITE_SIZE = 10;
  localparam int IMG_DIM     = 10;
  // visible sprite extent: the image is transparent outside its 10 by 10 area
  localparam int SPRITE_LIM  = (SPRITE_SIZE < IMG_DIM) ? SPRITE_SIZE : IMG_DIM;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int COLOR_W = 8;
  localparam int DELTA_W = 12;
  localparam int SUM_W   = 14;
  localparam int IMG_IDX_W = 4;

  typedef enum logic [2:0] {
    REQ_PIXEL  = 3'd0,
    REQ_MOVE_X = 3'd1,
    REQ_MOVE_Y = 3'd2,
    REQ_BUTTON = 3'd3,
    REQ_KEYS   = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    BTN_RELEASE = 2'd0,
    BTN_PRESS   = 2'd1
  } btn_code_t;

  typedef enum logic {
    RES_PIXEL  = 1'b0,
    RES_COMMIT = 1'b1
  } res_kind_t;

  localparam logic [COLOR_W-1:0] KEY_COLOR0 = 8'h0f;
  localparam logic [COLOR_W-1:0] KEY_COLOR1 = 8'h3c;
  localparam logic [COLOR_W-1:0] KEY_COLOR2 = 8'hf0;
  localparam logic [COLOR_W-1:0] KEY_COLOR3 = 8'hc0;

  typedef logic [COLOR_W-1:0] img_row_t [IMG_DIM];
  typedef img_row_t img_t [IMG_DIM];

  localparam img_t SPRITE_IMG = '{
    '{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0  },
    '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0  },
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd250},
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd0  }
  };

  function automatic logic [COLOR_W-1:0] sprite_pixel(
    input logic [IMG_IDX_W-1:0] row,
    input logic [IMG_IDX_W-1:0] col
  );
    logic [COLOR_W-1:0] val;
    val = 8'd0;
    if (int'(row) < IMG_DIM && int'(col) < IMG_DIM) begin
      val = SPRITE_IMG[row][col];
    end
    return val;
  endfunction

endpackage
`default_nettype wire

### rtl/cursor_rubber_band_overlay_core.sv
// cursor sprite and rubber-band rectangle overlay: top level
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | request type, pixel, move, button, keys
//  out_    | output    | out_valid / out_stall | composed pixel or rectangle commit
//
// one item per cycle sustained while in_stall is low; an item passes from the input register
// through the compose/update logic into the result register
// cursor, button, anchor and color state update as the item leaves the input register
// rst_n is synchronous; it clears valids and the state to screen center, released, black
// in_stall rises only when a result-producing item waits behind a stalled full result
`timescale 1ns / 1ps
`default_nettype none
module cursor_rubber_band_overlay_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [2:0]                   in_req_type,
  input  wire  [crbo_pkg::COL_W-1:0]   in_pix_x,
  input  wire  [crbo_pkg::ROW_W-1:0]   in_pix_y,
  input  wire  [crbo_pkg::COLOR_W-1:0] in_background_color,
  input  wire  signed [crbo_pkg::DELTA_W-1:0] in_move_delta,
  input  wire  [1:0]                   in_button_value,
  input  wire  [3:0]                   in_key_bits,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_result_kind,
  output logic [crbo_pkg::COLOR_W-1:0] out_pixel_color,
  output logic [crbo_pkg::COL_W-1:0]   out_rect_left,
  output logic [crbo_pkg::COL_W-1:0]   out_rect_right,
  output logic [crbo_pkg::ROW_W-1:0]   out_rect_top,
  output logic [crbo_pkg::ROW_W-1:0]   out_rect_bottom,
  output logic [crbo_pkg::COLOR_W-1:0] out_rect_color
);

  // input register
  logic                                s1_valid_r;
  logic [2:0]                          s1_type_r;
  logic [crbo_pkg::COL_W-1:0]          s1_px_r;
  logic [crbo_pkg::ROW_W-1:0]          s1_py_r;
  logic [crbo_pkg::COLOR_W-1:0]        s1_bg_r;
  logic signed [crbo_pkg::DELTA_W-1:0] s1_delta_r;
  logic [1:0]                          s1_btn_r;
  logic [3:0]                          s1_keys_r;

  // block state
  logic [crbo_pkg::COL_W-1:0]   cursor_col_r, cursor_col_nxt;
  logic [crbo_pkg::ROW_W-1:0]   cursor_row_r, cursor_row_nxt;
  logic                         button_held_r, button_held_nxt;
  logic [crbo_pkg::COL_W-1:0]   anchor_col_r, anchor_col_nxt;
  logic [crbo_pkg::ROW_W-1:0]   anchor_row_r, anchor_row_nxt;
  logic [crbo_pkg::COLOR_W-1:0] draw_color_r, draw_color_nxt;

  // result register
  logic                         out_valid_r;
  logic                         out_kind_r, out_kind_nxt;
  logic [crbo_pkg::COLOR_W-1:0] out_pixel_r, out_pixel_nxt;
  logic [crbo_pkg::COL_W-1:0]   out_left_r, out_left_nxt;
  logic [crbo_pkg::COL_W-1:0]   out_right_r, out_right_nxt;
  logic [crbo_pkg::ROW_W-1:0]   out_top_r, out_top_nxt;
  logic [crbo_pkg::ROW_W-1:0]   out_bottom_r, out_bottom_nxt;
  logic [crbo_pkg::COLOR_W-1:0] out_rcolor_r, out_rcolor_nxt;

  logic s1_has_res;
  logic out_free;
  logic s1_adv;
  logic s1_fire;

  logic [crbo_pkg::COL_W-1:0]   band_left, band_right;
  logic [crbo_pkg::ROW_W-1:0]   band_top, band_bottom;
  logic                         in_band;
  logic [crbo_pkg::COL_W-1:0]   spr_dx;
  logic [crbo_pkg::ROW_W-1:0]   spr_dy;
  logic                         spr_hit;
  logic [crbo_pkg::COLOR_W-1:0] spr_val;
  logic [crbo_pkg::COLOR_W-1:0] composed;

  logic signed [crbo_pkg::SUM_W-1:0] delta_ext;
  logic signed [crbo_pkg::SUM_W-1:0] col_sum;
  logic signed [crbo_pkg::SUM_W-1:0] row_sum;
  logic [crbo_pkg::COL_W-1:0]        col_clamped;
  logic [crbo_pkg::ROW_W-1:0]        row_clamped;
  logic [crbo_pkg::COLOR_W-1:0]      key_color;
  logic                              key_hit;

  // ---------------------------------------------------------------- handshake
  always_comb begin
    s1_has_res = 1'b0;
    case (s1_type_r)
      crbo_pkg::REQ_PIXEL:  s1_has_res = 1'b1;
      crbo_pkg::REQ_BUTTON: s1_has_res = (s1_btn_r == crbo_pkg::BTN_RELEASE) && button_held_r;
      default:              s1_has_res = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_has_res || out_free;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_type_r  <= in_req_type;
      s1_px_r    <= in_pix_x;
      s1_py_r    <= in_pix_y;
      s1_bg_r    <= in_background_color;
      s1_delta_r <= in_move_delta;
      s1_btn_r   <= in_button_value;
      s1_keys_r  <= in_key_bits;
    end
  end

  // ---------------------------------------------------------------- compose
  always_comb begin
    band_left   = (anchor_col_r < cursor_col_r) ? anchor_col_r : cursor_col_r;
    band_right  = (anchor_col_r < cursor_col_r) ? cursor_col_r : anchor_col_r;
    band_top    = (anchor_row_r < cursor_row_r) ? anchor_row_r : cursor_row_r;
    band_bottom = (anchor_row_r < cursor_row_r) ? cursor_row_r : anchor_row_r;
  end

  assign in_band = button_held_r && (s1_px_r >= band_left) && (s1_px_r <= band_right)
                   && (s1_py_r >= band_top) && (s1_py_r <= band_bottom);

  assign spr_dx = s1_px_r - cursor_col_r;
  assign spr_dy = s1_py_r - cursor_row_r;

  always_comb begin
    spr_hit = (32'(s1_px_r) < 32'(crbo_pkg::SCREEN_W))
              && (32'(s1_py_r) < 32'(crbo_pkg::SCREEN_H))
              && (s1_px_r >= cursor_col_r) && (s1_py_r >= cursor_row_r)
              && (32'(spr_dx) < 32'(crbo_pkg::SPRITE_LIM))
              && (32'(spr_dy) < 32'(crbo_pkg::SPRITE_LIM));
    spr_val = crbo_pkg::sprite_pixel(spr_dy[crbo_pkg::IMG_IDX_W-1:0],
                                     spr_dx[crbo_pkg::IMG_IDX_W-1:0]);
    composed = s1_bg_r;
    if (in_band) begin
      composed = draw_color_r;
    end
    // zero sprite pixels are transparent
    if (spr_hit && spr_val != '0) begin
      composed = spr_val;
    end
  end

  // ---------------------------------------------------------------- moves and keys
  assign delta_ext = {{(crbo_pkg::SUM_W-crbo_pkg::DELTA_W){s1_delta_r[crbo_pkg::DELTA_W-1]}},
                      s1_delta_r};
  assign col_sum = $signed({{(crbo_pkg::SUM_W-crbo_pkg::COL_W){1'b0}}, cursor_col_r}) + delta_ext;
  assign row_sum = $signed({{(crbo_pkg::SUM_W-crbo_pkg::ROW_W){1'b0}}, cursor_row_r}) + delta_ext;

  always_comb begin
    if (col_sum < 0) begin
      col_clamped = '0;
    end else if (col_sum > crbo_pkg::SUM_W'(crbo_pkg::SCREEN_W - 1)) begin
      col_clamped = crbo_pkg::COL_W'(crbo_pkg::SCREEN_W - 1);
    end else begin
      col_clamped = col_sum[crbo_pkg::COL_W-1:0];
    end
    if (row_sum < 0) begin
      row_clamped = '0;
    end else if (row_sum > crbo_pkg::SUM_W'(crbo_pkg::SCREEN_H - 1)) begin
      row_clamped = crbo_pkg::ROW_W'(crbo_pkg::SCREEN_H - 1);
    end else begin
      row_clamped = row_sum[crbo_pkg::ROW_W-1:0];
    end
  end

  // the highest set key bit picks the draw color: key 3 has priority over key 0
  always_comb begin
    key_hit   = 1'b1;
    key_color = draw_color_r;
    if (s1_keys_r[3]) begin
      key_color = crbo_pkg::KEY_COLOR3;
    end else if (s1_keys_r[2]) begin
      key_color = crbo_pkg::KEY_COLOR2;
    end else if (s1_keys_r[1]) begin
      key_color = crbo_pkg::KEY_COLOR1;
    end else if (s1_keys_r[0]) begin
      key_color = crbo_pkg::KEY_COLOR0;
    end else begin
      key_hit = 1'b0;
    end
  end

  // ---------------------------------------------------------------- state update
  always_comb begin
    cursor_col_nxt  = cursor_col_r;
    cursor_row_nxt  = cursor_row_r;
    button_held_nxt = button_held_r;
    anchor_col_nxt  = anchor_col_r;
    anchor_row_nxt  = anchor_row_r;
    draw_color_nxt  = draw_color_r;
    if (s1_fire) begin
      case (s1_type_r)
        crbo_pkg::REQ_MOVE_X: cursor_col_nxt = col_clamped;
        crbo_pkg::REQ_MOVE_Y: cursor_row_nxt = row_clamped;
        crbo_pkg::REQ_BUTTON: begin
          if (s1_btn_r == crbo_pkg::BTN_PRESS && !button_held_r) begin
            button_held_nxt = 1'b1;
            anchor_col_nxt  = cursor_col_r;
            anchor_row_nxt  = cursor_row_r;
          end else if (s1_btn_r == crbo_pkg::BTN_RELEASE && button_held_r) begin
            button_held_nxt = 1'b0;
          end
        end
        crbo_pkg::REQ_KEYS: begin
          if (key_hit) begin
            draw_color_nxt = key_color;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r  <= crbo_pkg::COL_W'(crbo_pkg::SCREEN_W / 2);
      cursor_row_r  <= crbo_pkg::ROW_W'(crbo_pkg::SCREEN_H / 2);
      button_held_r <= 1'b0;
      anchor_col_r  <= '0;
      anchor_row_r  <= '0;
      draw_color_r  <= '0;
    end else begin
      cursor_col_r  <= cursor_col_nxt;
      cursor_row_r  <= cursor_row_nxt;
      button_held_r <= button_held_nxt;
      anchor_col_r  <= anchor_col_nxt;
      anchor_row_r  <= anchor_row_nxt;
      draw_color_r  <= draw_color_nxt;
    end
  end

  // ---------------------------------------------------------------- result register
  always_comb begin
    out_kind_nxt   = crbo_pkg::RES_PIXEL;
    out_pixel_nxt  = composed;
    out_left_nxt   = '0;
    out_right_nxt  = '0;
    out_top_nxt    = '0;
    out_bottom_nxt = '0;
    out_rcolor_nxt = '0;
    if (s1_type_r != crbo_pkg::REQ_PIXEL) begin
      out_kind_nxt   = crbo_pkg::RES_COMMIT;
      out_pixel_nxt  = '0;
      out_left_nxt   = band_left;
      out_right_nxt  = band_right;
      out_top_nxt    = band_top;
      out_bottom_nxt = band_bottom;
      out_rcolor_nxt = draw_color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && s1_has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_res) begin
      out_kind_r   <= out_kind_nxt;
      out_pixel_r  <= out_pixel_nxt;
      out_left_r   <= out_left_nxt;
      out_right_r  <= out_right_nxt;
      out_top_r    <= out_top_nxt;
      out_bottom_r <= out_bottom_nxt;
      out_rcolor_r <= out_rcolor_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_pixel_color = out_pixel_r;
  assign out_rect_left   = out_left_r;
  assign out_rect_right  = out_right_r;
  assign out_rect_top    = out_top_r;
  assign out_rect_bottom = out_bottom_r;
  assign out_rect_color  = out_rcolor_r;

  // ---------------------------------------------------------------- assertions
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cursor_col_r) < 32'(crbo_pkg::SCREEN_W)) && (32'(cursor_row_r) < 32'(crbo_pkg::SCREEN_H)))
    else $error("cursor left the screen");

  a_commit_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == crbo_pkg::RES_COMMIT |->
      out_rect_left <= out_rect_right && out_rect_top <= out_rect_bottom && out_pixel_color == '0)
    else $error("commit item with unsorted corners or pixel color");

  a_press_from_button: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(button_held_r) |-> $past(s1_fire && s1_type_r == crbo_pkg::REQ_BUTTON))
    else $error("button held without a button item");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_has_res && out_valid_r)
    else $error("input stalled with nothing blocking");

endmodule
`default_nettype wire
